// ----- hw/rtl/bpdw_pkg.sv -----
package bpdw_pkg;

    localparam int PIXEL_COUNT_DEF = 65536;

    // configuration register indexes
    localparam logic CFG_SAMPLE_RATE       = 1'b0;
    localparam logic CFG_SAMPLES_PER_METER = 1'b1;

    localparam logic [28:0] SAMPLE_RATE_RST       = 29'd40000000;
    localparam logic [31:0] SAMPLES_PER_METER_RST = 32'd109226667;

    // floor(0.999 * 2^32)
    localparam logic [31:0] COS_CLAMP = 32'd4290672328;
    // one half sample in 2^-32 sample units
    localparam logic signed [62:0] ROUND_HALF = 63'sh0_8000_0000;

    typedef struct packed {
        logic [15:0]          pix;
        logic                 first;
        logic                 fault;
        logic signed [65:0]   dot;
        logic signed [62:0]   bb;
        logic [65:0]          dist2;
    } t_sq_side;

    typedef struct packed {
        logic [15:0] pix;
        logic        first;
        logic        fault;
        logic [15:0] idx;
        logic [65:0] dist2;
        logic        sat;
    } t_div1_side;

    typedef struct packed {
        logic [15:0] pix;
        logic        first;
        logic        fault;
        logic [15:0] idx;
        logic        big;
        logic        sat;
    } t_div2_side;

    typedef struct packed {
        logic [15:0] pix;
        logic [15:0] idx;
        logic [31:0] weight;
        logic        fault;
    } t_result;

endpackage

// ----- hw/rtl/backprojection_delay_and_weight.sv -----
// Back-projection delay and weight unit. Takes one pixel/receiver pair per
// clock while the skid slot is free and offers, for each accepted input
// transaction: the pixel index, the rounded time-sample index
// (d*samples_per_meter - delay*sample_rate, saturated to 0..65535), the
// clamped-cosine-over-d^2 weight in Q16.16 and the pixel's running total
// weight from a PIXEL_COUNT x 48 bit memory. Throughput is one transaction per
// cycle while the skid slot is free. The pipeline runs through three input
// stages, the two square roots running side by side (33 stages), stage M, the
// two restoring dividers (33 and 32 stages, one bit per stage) with stage C
// between them, the store stage and the output register.
// A transaction with first_step set starts a new total for its pixel; reading
// a total that was never written gives an undefined sum. Zero distance or
// receiver range sets fault and gives the maximum weight. Configuration may be
// written only when no transaction is in flight.
module backprojection_delay_and_weight #(
    parameter int PIXEL_COUNT = bpdw_pkg::PIXEL_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pixel_index, pixel_x, pixel_y, receiver_x, receiver_y, receiver_delay
    input  logic [175:0] s_axis_tdata,
    // first_step
    input  logic [0:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pixel_index, sample_index, angular_weight, total_weight
    output logic [111:0] m_axis_tdata,
    // fault
    output logic [0:0]   m_axis_tuser
);
    // configuration registers
    logic [28:0] r_sample_rate;
    logic [31:0] r_samples_per_meter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate       <= bpdw_pkg::SAMPLE_RATE_RST;
            r_samples_per_meter <= bpdw_pkg::SAMPLES_PER_METER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpdw_pkg::CFG_SAMPLE_RATE:       r_sample_rate <= i_cfg_data[28:0];
                bpdw_pkg::CFG_SAMPLES_PER_METER: r_samples_per_meter <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances together; stalls only once the skid slot is full
    logic w_en;
    logic r_sk_valid;
    assign w_en          = !r_sk_valid;
    assign s_axis_tready = w_en;

    // stage 1: unpack, coordinate differences
    logic signed [31:0] w_px, w_py, w_rx, w_ry;
    assign w_px = s_axis_tdata[47:16];
    assign w_py = s_axis_tdata[79:48];
    assign w_rx = s_axis_tdata[111:80];
    assign w_ry = s_axis_tdata[143:112];

    logic               r1_valid, r1_first;
    logic [15:0]        r1_pix;
    logic signed [31:0] r1_rx, r1_ry, r1_dly;
    logic signed [32:0] r1_dx, r1_dy;

    // stage 2: products
    logic               r2_valid, r2_first;
    logic [15:0]        r2_pix;
    logic signed [65:0] r2_dxx, r2_dyy;
    logic signed [63:0] r2_rxx, r2_ryy;
    logic signed [64:0] r2_s1, r2_s2;
    logic signed [61:0] r2_bprod;

    // stage 3: sums; delay term biased by half a sample for rounding
    logic               r3_valid, r3_first;
    logic [15:0]        r3_pix;
    logic [65:0]        r3_dist2;
    logic [63:0]        r3_r2;
    logic signed [65:0] r3_dot;
    logic signed [62:0] r3_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pix   <= s_axis_tdata[15:0];
            r1_first <= s_axis_tuser[0];
            r1_rx    <= w_rx;
            r1_ry    <= w_ry;
            r1_dly   <= s_axis_tdata[175:144];
            r1_dx    <= {w_px[31], w_px} - {w_rx[31], w_rx};
            r1_dy    <= {w_py[31], w_py} - {w_ry[31], w_ry};

            r2_pix   <= r1_pix;
            r2_first <= r1_first;
            r2_dxx   <= r1_dx * r1_dx;
            r2_dyy   <= r1_dy * r1_dy;
            r2_rxx   <= r1_rx * r1_rx;
            r2_ryy   <= r1_ry * r1_ry;
            r2_s1    <= r1_rx * r1_dx;
            r2_s2    <= r1_ry * r1_dy;
            r2_bprod <= r1_dly * $signed({1'b0, r_sample_rate});

            r3_pix   <= r2_pix;
            r3_first <= r2_first;
            r3_dist2 <= $unsigned(r2_dxx) + $unsigned(r2_dyy);
            r3_r2    <= $unsigned(r2_rxx) + $unsigned(r2_ryy);
            r3_dot   <= r2_s1 + r2_s2;
            r3_bb    <= r2_bprod - bpdw_pkg::ROUND_HALF;
        end
    end

    // square roots of d^2 and r^2
    bpdw_pkg::t_sq_side w_sq_in, w_sq_out;
    logic               w_sq_valid;
    logic [32:0]        w_dist, w_range;
    logic [$bits(bpdw_pkg::t_sq_side)-1:0] w_sq_out_vec;

    assign w_sq_in.pix   = r3_pix;
    assign w_sq_in.first = r3_first;
    assign w_sq_in.fault = (r3_dist2 == '0) || (r3_r2 == '0);
    assign w_sq_in.dot   = r3_dot;
    assign w_sq_in.bb    = r3_bb;
    assign w_sq_in.dist2 = r3_dist2;

    bpdw_isqrt #(
        .W  (66),
        .SW ($bits(bpdw_pkg::t_sq_side))
    ) u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r3_valid),
        .i_a      (r3_dist2),
        .i_b      ({2'b00, r3_r2}),
        .i_side   (w_sq_in),
        .o_valid  (w_sq_valid),
        .o_root_a (w_dist),
        .o_root_b (w_range),
        .o_side   (w_sq_out_vec)
    );
    assign w_sq_out = bpdw_pkg::t_sq_side'(w_sq_out_vec);

    // stage M: r*d, |dot|, d*samples_per_meter
    logic [65:0] w_absdot_full;
    assign w_absdot_full = w_sq_out.dot[65] ? 66'(-w_sq_out.dot) : 66'(w_sq_out.dot);

    logic               rm_valid, rm_first, rm_fault;
    logic [15:0]        rm_pix;
    logic [65:0]        rm_den, rm_dist2;
    logic [64:0]        rm_absdot, rm_tprod;
    logic signed [62:0] rm_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else if (w_en) begin
            rm_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_pix    <= w_sq_out.pix;
            rm_first  <= w_sq_out.first;
            rm_fault  <= w_sq_out.fault;
            rm_dist2  <= w_sq_out.dist2;
            rm_bb     <= w_sq_out.bb;
            rm_den    <= w_range * w_dist;
            rm_absdot <= w_absdot_full[64:0];
            rm_tprod  <= w_dist * r_samples_per_meter;
        end
    end

    // sample index: t + half, negative to zero, large to 65535
    logic signed [66:0] w_t2;
    logic [15:0]        w_idx;
    assign w_t2 = $signed({2'b00, rm_tprod}) - rm_bb;

    always_comb begin
        if (w_t2 < 67'(bpdw_pkg::ROUND_HALF)) begin
            w_idx = 16'd0;
        end else if (w_t2[66:48] != '0) begin
            w_idx = 16'hFFFF;
        end else begin
            w_idx = w_t2[47:32];
        end
    end

    // cosine: |dot| * 2^32 / (r * d); quotient at or above 2^33 flagged up front
    bpdw_pkg::t_div1_side w_d1_in, w_d1_out;
    logic                 w_d1_valid;
    logic [32:0]          w_q1;
    logic [$bits(bpdw_pkg::t_div1_side)-1:0] w_d1_out_vec;

    assign w_d1_in.pix   = rm_pix;
    assign w_d1_in.first = rm_first;
    assign w_d1_in.fault = rm_fault;
    assign w_d1_in.idx   = w_idx;
    assign w_d1_in.dist2 = rm_dist2;
    assign w_d1_in.sat   = ({2'b00, rm_absdot[64:1]} >= rm_den);

    bpdw_div #(
        .DW (66),
        .QW (33),
        .SW ($bits(bpdw_pkg::t_div1_side))
    ) u_div_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rm_valid),
        .i_rem   ({2'b00, rm_absdot[64:1]}),
        .i_low   ({rm_absdot[0], 32'd0}),
        .i_den   (rm_den),
        .i_side  (w_d1_in),
        .o_valid (w_d1_valid),
        .o_quo   (w_q1),
        .o_side  (w_d1_out_vec)
    );
    assign w_d1_out = bpdw_pkg::t_div1_side'(w_d1_out_vec);

    // stage C: clamp cosine to 0.999
    logic        rc_valid, rc_first, rc_fault;
    logic [15:0] rc_pix, rc_idx;
    logic [65:0] rc_dist2;
    logic [31:0] rc_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_valid <= 1'b0;
        end else if (w_en) begin
            rc_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rc_pix   <= w_d1_out.pix;
            rc_first <= w_d1_out.first;
            rc_fault <= w_d1_out.fault;
            rc_idx   <= w_d1_out.idx;
            rc_dist2 <= w_d1_out.dist2;
            if (w_d1_out.sat || (w_q1 > 33'(bpdw_pkg::COS_CLAMP))) begin
                rc_cos <= bpdw_pkg::COS_CLAMP;
            end else begin
                rc_cos <= w_q1[31:0];
            end
        end
    end

    // weight: cos * 2^24 / d^2
    bpdw_pkg::t_div2_side w_d2_in, w_d2_out;
    logic                 w_d2_valid;
    logic [31:0]          w_q2;
    logic [$bits(bpdw_pkg::t_div2_side)-1:0] w_d2_out_vec;

    assign w_d2_in.pix   = rc_pix;
    assign w_d2_in.first = rc_first;
    assign w_d2_in.fault = rc_fault;
    assign w_d2_in.idx   = rc_idx;
    assign w_d2_in.big   = (rc_dist2[65:64] != 2'b00);
    assign w_d2_in.sat   = ({40'd0, rc_cos[31:8]} >= rc_dist2[63:0]);

    bpdw_div #(
        .DW (64),
        .QW (32),
        .SW ($bits(bpdw_pkg::t_div2_side))
    ) u_div_wt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rc_valid),
        .i_rem   ({40'd0, rc_cos[31:8]}),
        .i_low   ({rc_cos[7:0], 24'd0}),
        .i_den   (rc_dist2[63:0]),
        .i_side  (w_d2_in),
        .o_valid (w_d2_valid),
        .o_quo   (w_q2),
        .o_side  (w_d2_out_vec)
    );
    assign w_d2_out = bpdw_pkg::t_div2_side'(w_d2_out_vec);

    logic [31:0] w_weight;

    always_comb begin
        if (w_d2_out.fault) begin
            w_weight = '1;
        end else if (w_d2_out.big) begin
            w_weight = '0;
        end else if (w_d2_out.sat) begin
            w_weight = '1;
        end else begin
            w_weight = w_q2;
        end
    end

    bpdw_pkg::t_result w_res;
    assign w_res.pix    = w_d2_out.pix;
    assign w_res.idx    = w_d2_out.idx;
    assign w_res.weight = w_weight;
    assign w_res.fault  = w_d2_out.fault;

    // total-weight read-modify-write
    logic              w_st_valid;
    logic [47:0]       w_st_total;
    bpdw_pkg::t_result w_st_item;

    bpdw_store #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_valid),
        .i_first (w_d2_out.first),
        .i_item  (w_res),
        .o_valid (w_st_valid),
        .o_total (w_st_total),
        .o_item  (w_st_item)
    );

    // output register plus one skid slot
    logic              r_o_valid;
    bpdw_pkg::t_result r_o_item, r_sk_item;
    logic [47:0]       r_o_total, r_sk_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_o_valid || m_axis_tready) begin
            if (r_sk_valid) begin
                r_o_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_o_valid <= w_st_valid;
            end
        end else if (w_en && w_st_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || m_axis_tready) begin
            if (r_sk_valid) begin
                r_o_item  <= r_sk_item;
                r_o_total <= r_sk_total;
            end else begin
                r_o_item  <= w_st_item;
                r_o_total <= w_st_total;
            end
        end else if (w_en) begin
            r_sk_item  <= w_st_item;
            r_sk_total <= w_st_total;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_total, r_o_item.weight, r_o_item.idx, r_o_item.pix};
    assign m_axis_tuser  = r_o_item.fault;

    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("skid slot holds a transaction while output is empty");

    a_fault_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:32] == 32'hFFFF_FFFF))
        else $error("fault without maximum weight");

    a_total_covers_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (32'(m_axis_tdata[15:0]) < 32'(PIXEL_COUNT)))
            |-> (m_axis_tdata[111:64] >= 48'(m_axis_tdata[63:32])))
        else $error("total weight below this step's weight");

endmodule

// ----- hw/rtl/bpdw_isqrt.sv -----
// Two-lane pipelined floor square root, one root bit per stage.
module bpdw_isqrt #(
    parameter int W  = 66,
    parameter int SW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [W/2-1:0]    o_root_a,
    output logic [W/2-1:0]    o_root_b,
    output logic [SW-1:0]     o_side
);
    localparam int L  = W / 2;
    localparam int RW = L + 2;

    logic [W-1:0]  r_n    [2][L];
    logic [RW-1:0] r_rem  [2][L];
    logic [L-1:0]  r_root [2][L];
    logic [SW-1:0] r_side [L];
    logic          r_valid[L];

    for (genvar s = 0; s < L; s++) begin : g_stage
        logic          w_valid_in;
        logic [SW-1:0] w_side_in;

        if (s == 0) begin : g_head
            assign w_valid_in = i_valid;
            assign w_side_in  = i_side;
        end else begin : g_body
            assign w_valid_in = r_valid[s-1];
            assign w_side_in  = r_side[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= w_side_in;
            end
        end

        for (genvar k = 0; k < 2; k++) begin : g_lane
            logic [W-1:0]  w_n_in;
            logic [RW-1:0] w_rem_in, w_shift, w_trial;
            logic [L-1:0]  w_root_in;
            logic          w_ge;

            if (s == 0) begin : g_head
                assign w_n_in    = (k == 0) ? i_a : i_b;
                assign w_rem_in  = '0;
                assign w_root_in = '0;
            end else begin : g_body
                assign w_n_in    = r_n[k][s-1];
                assign w_rem_in  = r_rem[k][s-1];
                assign w_root_in = r_root[k][s-1];
            end

            assign w_shift = {w_rem_in[RW-3:0], w_n_in[W-1:W-2]};
            assign w_trial = {w_root_in, 2'b01};
            assign w_ge    = (w_shift >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k][s]    <= {w_n_in[W-3:0], 2'b00};
                    r_rem[k][s]  <= w_ge ? (w_shift - w_trial) : w_shift;
                    r_root[k][s] <= {w_root_in[L-2:0], w_ge};
                end
            end
        end
    end

    assign o_valid  = r_valid[L-1];
    assign o_root_a = r_root[0][L-1];
    assign o_root_b = r_root[1][L-1];
    assign o_side   = r_side[L-1];

endmodule

// ----- hw/rtl/bpdw_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees i_rem < i_den when the quotient is to be used.
module bpdw_div #(
    parameter int DW = 66,
    parameter int QW = 33,
    parameter int SW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_rem,
    input  logic [QW-1:0]     i_low,
    input  logic [DW-1:0]     i_den,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quo,
    output logic [SW-1:0]     o_side
);
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_valid[QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          w_valid_in;
        logic [DW-1:0] w_rem_in, w_den_in;
        logic [QW-1:0] w_low_in, w_quo_in;
        logic [SW-1:0] w_side_in;
        logic [DW:0]   w_shift, w_diff;
        logic          w_ge;

        if (s == 0) begin : g_head
            assign w_valid_in = i_valid;
            assign w_rem_in   = i_rem;
            assign w_low_in   = i_low;
            assign w_den_in   = i_den;
            assign w_quo_in   = '0;
            assign w_side_in  = i_side;
        end else begin : g_body
            assign w_valid_in = r_valid[s-1];
            assign w_rem_in   = r_rem[s-1];
            assign w_low_in   = r_low[s-1];
            assign w_den_in   = r_den[s-1];
            assign w_quo_in   = r_quo[s-1];
            assign w_side_in  = r_side[s-1];
        end

        assign w_shift = {w_rem_in, w_low_in[QW-1]};
        assign w_diff  = w_shift - {1'b0, w_den_in};
        assign w_ge    = (w_shift >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
                r_low[s]  <= {w_low_in[QW-2:0], 1'b0};
                r_den[s]  <= w_den_in;
                r_quo[s]  <= {w_quo_in[QW-2:0], w_ge};
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ----- hw/rtl/bpdw_store.sv -----
// Per-pixel total-weight memory: registered read on entry, then add and write back.
// The write landing on the same edge as the read is forwarded.
module bpdw_store #(
    parameter int PIXEL_COUNT = bpdw_pkg::PIXEL_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_first,
    input  bpdw_pkg::t_result    i_item,
    output logic                 o_valid,
    output logic [47:0]          o_total,
    output bpdw_pkg::t_result    o_item
);
    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    logic [47:0] mem_total [PIXEL_COUNT];

    logic [31:0]       w_pix_ext;
    logic [AW-1:0]     w_addr;
    logic              w_inr;
    logic [47:0]       w_prev, w_base, w_total;
    logic [48:0]       w_sum;
    logic              w_wr;

    logic              r_valid, r_first, r_inr;
    logic [AW-1:0]     r_addr;
    bpdw_pkg::t_result r_item;
    logic [47:0]       r_rd;
    logic              r_fw_vld;
    logic [AW-1:0]     r_fw_addr;
    logic [47:0]       r_fw_data;

    assign w_pix_ext = 32'(i_item.pix);
    assign w_addr    = w_pix_ext[AW-1:0];
    assign w_inr     = (w_pix_ext < 32'(PIXEL_COUNT));

    assign w_prev  = (r_fw_vld && (r_fw_addr == r_addr)) ? r_fw_data : r_rd;
    assign w_base  = r_first ? 48'd0 : w_prev;
    assign w_sum   = {1'b0, w_base} + 49'(r_item.weight);
    assign w_total = w_sum[48] ? '1 : w_sum[47:0];
    assign w_wr    = i_en && r_valid && r_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_fw_vld <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (r_valid && r_inr) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first <= i_first;
            r_inr   <= w_inr;
            r_addr  <= w_addr;
            r_item  <= i_item;
            r_rd    <= mem_total[w_addr];
        end
        if (w_wr) begin
            mem_total[r_addr] <= w_total;
            r_fw_addr         <= r_addr;
            r_fw_data         <= w_total;
        end
    end

    assign o_valid = r_valid;
    assign o_total = r_inr ? w_total : 48'd0;
    assign o_item  = r_item;

endmodule

// ----- verif/backprojection_delay_and_weight_tb.sv -----
module backprojection_delay_and_weight_tb;

    localparam int  LATENCY   = 105;
    localparam int  CYCLE_CAP = 2000000;
    localparam int  HOLD_LEN  = 400;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    // one input transaction
    typedef struct {
        logic [15:0] pix;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] delay;
        logic        first;
    } t_geom;

    // one predicted result transaction
    typedef struct {
        logic [15:0] pix;
        logic [15:0] idx;
        logic [31:0] weight;
        logic [47:0] total;
        logic        fault;
    } t_outcome;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = bpdw_pkg::CFG_SAMPLE_RATE;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata = '0;  // pix, px, py, rx, ry, delay (LSB first)
    logic [0:0]   s_axis_tuser = '0;  // first_step
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;       // pix, sample_index, weight, total (LSB first)
    logic [0:0]   m_axis_tuser;       // fault

    backprojection_delay_and_weight uut (.*);

    // clock: period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_geom        geom_q[$];
    t_outcome     outcome_q[$];
    logic [47:0]  pixel_total[int];   // predictor's copy of the total-weight store
    bit           pixel_written[int]; // entries already set up by the stimulus
    logic [28:0]  rate_reg = bpdw_pkg::SAMPLE_RATE_RST;
    logic [31:0]  spm_reg  = bpdw_pkg::SAMPLES_PER_METER_RST;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_left = 0;
    int           errors = 0;
    int           cycles = 0;
    int           n_sent = 0;
    int           n_checked = 0;
    int           n_faults = 0;
    bit           offering = 0;

    // floor square root of a 66-bit value
    function automatic logic [32:0] floor_root(logic [65:0] n);
        logic [32:0] r;
        logic [32:0] c;
        logic [65:0] sq;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (33'd1 << b);
            sq = 66'(c) * 66'(c);
            if (sq <= n) r = c;
        end
        return r;
    endfunction

    // expected result of one transaction; updates the store copy
    function automatic t_outcome predict_delay_weight(t_geom g);
        t_outcome o;
        logic signed [67:0] erx, ery, edx, edy, dot;
        logic [32:0]  adx, ady, arx, ary, dd, rr, adelay;
        logic [65:0]  d2, r2;
        logic [127:0] num, den, q, w;
        logic [31:0]  cosq;
        logic signed [127:0] t, b;
        logic [47:0]  prev;
        logic [48:0]  sum;
        erx = $signed(g.rx);
        ery = $signed(g.ry);
        edx = $signed(g.px) - erx;
        edy = $signed(g.py) - ery;
        adx = edx < 0 ? 33'(-edx) : 33'(edx);
        ady = edy < 0 ? 33'(-edy) : 33'(edy);
        arx = erx < 0 ? 33'(-erx) : 33'(erx);
        ary = ery < 0 ? 33'(-ery) : 33'(ery);
        d2 = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
        r2 = 66'(arx) * 66'(arx) + 66'(ary) * 66'(ary);
        dd = floor_root(d2);
        rr = floor_root(r2);
        o.fault = (d2 == 0) || (r2 == 0);
        if (o.fault) begin
            o.weight = '1;
        end else begin
            dot = -(erx * edx + ery * edy);
            if (dot < 0) dot = -dot;
            num = 128'(dot[65:0]) << 32;
            den = 128'(rr) * 128'(dd);
            q = num / den;
            cosq = (q > 128'(bpdw_pkg::COS_CLAMP)) ? bpdw_pkg::COS_CLAMP : q[31:0];
            if (d2[65:64] != 0) begin
                o.weight = '0;
            end else begin
                w = (128'(cosq) << 24) / 128'(d2);
                o.weight = (w > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
            end
        end
        // index in 2^-32 samples, rounded half away from zero
        adelay = g.delay[31] ? 33'(-$signed({g.delay[31], g.delay})) : 33'(g.delay);
        t = 128'(dd) * 128'(spm_reg);
        b = 128'(adelay) * 128'(rate_reg);
        if (g.delay[31]) b = -b;
        t = t - b;
        if (t < 0) begin
            o.idx = '0;
        end else begin
            t = (t + 128'sh8000_0000) >>> 32;
            o.idx = (t > 65535) ? 16'hFFFF : t[15:0];
        end
        prev = g.first ? 48'd0 : pixel_total[int'(g.pix)];
        sum = 49'(prev) + 49'(o.weight);
        o.total = (sum > 49'(TOTAL_MAX)) ? TOTAL_MAX : sum[47:0];
        pixel_total[int'(g.pix)] = o.total;
        o.pix = g.pix;
        return o;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch on %s at result %0d: got %0h, want %0h",
                 field, n_checked, got, want);
    endtask

    // ---------------- driver: offers queued transactions at the falling edge
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            outcome_q.push_back(predict_delay_weight(geom_q.pop_front()));
            offering = 0;
            n_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !offering) begin
            if (geom_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_axis_tdata <= {geom_q[0].delay, geom_q[0].ry, geom_q[0].rx,
                                 geom_q[0].py, geom_q[0].px, geom_q[0].pix};
                s_axis_tuser <= geom_q[0].first;
                s_axis_tvalid <= 1'b1;
                offering = 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left--;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // ---------------- monitor: compares each result with the oldest prediction
    always @(posedge i_clk) begin
        t_outcome e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                report("unexpected transaction", m_axis_tdata[63:0], 64'd0);
            end else begin
                e = outcome_q.pop_front();
                if (m_axis_tdata[15:0] !== e.pix)
                    report("out_pixel_index", m_axis_tdata[15:0], e.pix);
                if (m_axis_tdata[31:16] !== e.idx)
                    report("sample_index", m_axis_tdata[31:16], e.idx);
                if (m_axis_tdata[63:32] !== e.weight)
                    report("angular_weight", m_axis_tdata[63:32], e.weight);
                if (m_axis_tdata[111:64] !== e.total)
                    report("total_weight", m_axis_tdata[111:64], e.total);
                if (m_axis_tuser[0] !== e.fault)
                    report("fault", m_axis_tuser[0], e.fault);
                n_faults += e.fault;
            end
            n_checked++;
        end
    end

    // ---------------- watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------- stimulus
    task automatic add_item(logic [15:0] pix, logic [31:0] px, logic [31:0] py,
                            logic [31:0] rx, logic [31:0] ry, logic [31:0] delay,
                            logic first);
        t_geom g;
        g.pix = pix; g.px = px; g.py = py; g.rx = rx; g.ry = ry;
        g.delay = delay;
        // never accumulate onto an entry that was never written
        g.first = pixel_written.exists(int'(pix)) ? first : 1'b1;
        pixel_written[int'(pix)] = 1;
        geom_q.push_back(g);
    endtask

    // coordinate spread: full range, a few meters, or near the origin
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(8388608)) - 4194304);
            default: return 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] rand_delay();
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(200000)) - 50000);
            default: return $urandom_range(4000);
        endcase
    endfunction

    task automatic add_random(int count);
        logic [15:0] pix;
        logic [31:0] px, py;
        for (int i = 0; i < count; i++) begin
            // small pixel pool so totals build up, full range now and then
            pix = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(63));
            px = rand_coord();
            py = rand_coord();
            if ($urandom_range(19) == 0)
                add_item(pix, px, py, px, py, rand_delay(), $urandom_range(7) == 0);
            else
                add_item(pix, px, py, rand_coord(), rand_coord(), rand_delay(),
                         $urandom_range(7) == 0);
        end
    endtask

    task automatic write_cfg(logic index, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == bpdw_pkg::CFG_SAMPLE_RATE) rate_reg = value[28:0];
        else spm_reg = value;
    endtask

    task automatic drain();
        while (geom_q.size() > 0 || outcome_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 40) @(posedge i_clk);
    endtask

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE_M = 32'h0010_0000;

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset configuration, no idling
        add_item(16'd0,     ONE_M, 0, 0, 0, 0, 1);               // receiver at origin
        add_item(16'd0,     0, ONE_M, 0, 2*ONE_M, 0, 0);         // accumulate
        add_item(16'd1,     ONE_M, ONE_M, ONE_M, ONE_M, 0, 1);   // zero distance
        add_item(16'd2,     ONE_M, 0, 0, 0, 32'd1000, 1);        // zero range
        add_item(16'd3,     0, 0, 0, 0, 0, 1);                   // both zero
        add_item(16'hFFFF,  MAXP, MAXP, MINN, MINN, MAXP, 1);    // extremes
        add_item(16'hFFFF,  MINN, MINN, MAXP, MAXP, MINN, 0);
        add_item(16'h8000,  MINN, MAXP, MINN, MINN, 0, 1);
        add_item(16'd4,     ONE_M, ONE_M, 0, 1, MAXP, 1);        // negative index
        add_item(16'd5,     MAXP, 0, MINN, 0, MINN, 1);          // index saturates high
        add_item(16'd6,     32'd5, 32'd3, 32'd4, 32'd3, 0, 1);   // tiny distance
        add_item(16'd6,     32'd4, 32'd4, 32'd4, 32'd3, 0, 0);
        add_item(16'd7,     32'd100, 0, 32'd101, 0, 32'hFFFF_FFFF, 1); // cos clamp
        add_item(16'd8,     0, ONE_M, ONE_M, 0, 32'd107, 1);     // rounding near half
        add_item(16'd9,     ONE_M, 0, 0, ONE_M, 32'd0, 1);       // 45 degrees, cos 1/sqrt(2)
        add_item(16'd10,    32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                 32'hCCCC_CCCC, 32'h0F0F_0F0F, 1);
        add_item(16'h5555,  32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC,
                 32'h3333_3333, 32'hF0F0_F0F0, 1);
        add_item(16'hAAAA,  ONE_M, ONE_M, 0, ONE_M, 32'hFFFF_0000, 1);
        drain();

        // random phases over idling modes and register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            case (ph)
                1: begin write_cfg(bpdw_pkg::CFG_SAMPLE_RATE, 32'd1);
                         write_cfg(bpdw_pkg::CFG_SAMPLES_PER_METER, 32'd1); end
                2: begin write_cfg(bpdw_pkg::CFG_SAMPLE_RATE, 32'd500000000);
                         write_cfg(bpdw_pkg::CFG_SAMPLES_PER_METER, 32'hFFFF_FFFF); end
                3: begin write_cfg(bpdw_pkg::CFG_SAMPLE_RATE, bpdw_pkg::SAMPLE_RATE_RST);
                         write_cfg(bpdw_pkg::CFG_SAMPLES_PER_METER,
                                   bpdw_pkg::SAMPLES_PER_METER_RST); end
                5: begin write_cfg(bpdw_pkg::CFG_SAMPLE_RATE, $urandom_range(500000000, 1));
                         write_cfg(bpdw_pkg::CFG_SAMPLES_PER_METER,
                                   $urandom_range(32'hFFFF_FFFF, 1));
                   end
                6: begin write_cfg(bpdw_pkg::CFG_SAMPLE_RATE, 32'd1);
                         write_cfg(bpdw_pkg::CFG_SAMPLES_PER_METER, 32'hFFFF_FFFF); end
                default: ;
            endcase
            add_random(240);
            // long receiver hold-off while the sender keeps offering
            if (ph == 4) begin
                @(negedge i_clk);
                hold_left = HOLD_LEN;
            end
            drain();
        end

        $display("sent %0d transactions, checked %0d results (%0d faults)",
                 n_sent, n_checked, n_faults);
        $display("covered 5 register settings and 4 idling modes, one long stall");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
